/* design/worst_fit_partition_allocator_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the worst-fit partition allocator
// Shared shorthands for clocked properties with a synchronous active-low reset.
// ----------------------------------------------------------------------------
`ifndef WORST_FIT_PARTITION_ALLOCATOR_MACROS_SVH
`define WORST_FIT_PARTITION_ALLOCATOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WFPA_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define WFPA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/wfpa_pkg.sv */
// ----------------------------------------------------------------------------
// wfpa_pkg
// Sizes, codes and the controller state type of the worst-fit allocator.
// ----------------------------------------------------------------------------
package wfpa_pkg;

    localparam int NUM_BLOCKS = 16;
    localparam int SIZE_WIDTH = 16;
    localparam int IDX_W      = $clog2(NUM_BLOCKS);
    localparam int CNT_W      = $clog2(NUM_BLOCKS + 1);
    localparam int S_TDATA_W  = ((IDX_W + SIZE_WIDTH + 7) / 8) * 8;
    localparam int M_TDATA_W  = ((IDX_W + SIZE_WIDTH + 7) / 8) * 8;

    localparam logic KIND_LOAD    = 1'b0;
    localparam logic KIND_REQUEST = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } wfpa_state_t;

endpackage

/* design/worst_fit_partition_allocator.sv */
// ----------------------------------------------------------------------------
// worst_fit_partition_allocator
// Fixed-partition worst-fit allocator over a block size memory.
// ----------------------------------------------------------------------------
// A load word writes a block size into the size memory and frees that block;
// it returns nothing. A request word scans the in-use blocks one per cycle
// through the single read port of the size memory, keeping the free block
// with the largest leftover (ties to the higher index), then marks it taken
// and presents the result. A request occupies the block over the scan of the
// saturated in-use count and skips the scan when no block is in use; a
// result still waiting in the output register from the previous request
// holds the request in its finishing state until that word is taken. A
// further word is taken once the result has been registered, while it may
// still be waiting in the output register. The in-use count saturates at
// the number of blocks, and the taken flags are cleared by reset.
// ----------------------------------------------------------------------------
`include "worst_fit_partition_allocator_macros.svh"

module worst_fit_partition_allocator (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration: blocks_in_use
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [wfpa_pkg::CNT_W-1:0]        cfg_data,
    // input words
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [wfpa_pkg::S_TDATA_W-1:0]    s_tdata,  // block_index, size, zero pad
    input  logic                              s_tuser,  // kind
    // result words
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [wfpa_pkg::M_TDATA_W-1:0]    m_tdata,  // chosen_block, leftover, zero pad
    output logic                              m_tuser   // granted
);
    import wfpa_pkg::*;

    // Block size memory: no reset, read data registered.
    logic [SIZE_WIDTH-1:0] size_mem [NUM_BLOCKS];
    logic [SIZE_WIDTH-1:0] rd_data_reg;

    logic [NUM_BLOCKS-1:0] taken_reg;
    logic [CNT_W-1:0]      blocks_in_use_reg;

    wfpa_state_t           state_reg, state_next;
    logic [CNT_W-1:0]      limit_reg;
    logic [IDX_W-1:0]      scan_idx_reg;
    logic [IDX_W-1:0]      cmp_idx_reg;
    logic                  cmp_valid_reg;
    logic [SIZE_WIDTH-1:0] req_reg;
    logic                  found_reg;
    logic [IDX_W-1:0]      best_idx_reg;
    logic [SIZE_WIDTH-1:0] best_left_reg;

    logic                  m_tvalid_reg;
    logic                  granted_reg;
    logic [IDX_W-1:0]      chosen_reg;
    logic [SIZE_WIDTH-1:0] leftover_reg;

    logic [IDX_W-1:0]      in_index;
    logic [SIZE_WIDTH-1:0] in_size;
    logic                  in_accept;
    logic                  load_accept;
    logic                  req_accept;
    logic                  out_free;
    logic                  finish_fire;
    logic                  last_issue;
    logic [CNT_W-1:0]      cfg_limit;
    logic                  candidate;
    logic [SIZE_WIDTH-1:0] cand_left;

    assign in_index    = s_tdata[IDX_W-1:0];
    assign in_size     = s_tdata[IDX_W+SIZE_WIDTH-1:IDX_W];
    assign in_accept   = s_tvalid && s_tready;
    assign load_accept = in_accept && (s_tuser == KIND_LOAD);
    assign req_accept  = in_accept && (s_tuser == KIND_REQUEST);
    assign out_free    = !m_tvalid_reg || m_tready;
    assign finish_fire = (state_reg == ST_FINISH) && out_free;
    assign last_issue  = ({1'b0, scan_idx_reg} == (limit_reg - CNT_W'(1)));
    assign cfg_limit   = (blocks_in_use_reg > CNT_W'(NUM_BLOCKS)) ?
                         CNT_W'(NUM_BLOCKS) : blocks_in_use_reg;

    assign cfg_ready = 1'b1;

    // Compare stage: the word read last cycle against the request.
    assign candidate = cmp_valid_reg && !taken_reg[cmp_idx_reg] && (rd_data_reg >= req_reg);
    assign cand_left = rd_data_reg - req_reg;

    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (req_accept) begin
                    state_next = (cfg_limit == '0) ? ST_FINISH : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (last_issue) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Size memory port: write on a load, read one entry per scan cycle.
    always_ff @(posedge aclk) begin
        if (load_accept && ({1'b0, in_index} < CNT_W'(NUM_BLOCKS))) begin
            size_mem[in_index] <= in_size;
        end
        rd_data_reg <= size_mem[scan_idx_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blocks_in_use_reg <= '0;
            taken_reg         <= '0;
            cmp_valid_reg     <= 1'b0;
            found_reg         <= 1'b0;
            m_tvalid_reg      <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                blocks_in_use_reg <= cfg_data;
            end
            if (load_accept && ({1'b0, in_index} < CNT_W'(NUM_BLOCKS))) begin
                taken_reg[in_index] <= 1'b0;
            end
            if (finish_fire && found_reg) begin
                taken_reg[best_idx_reg] <= 1'b1;
            end
            cmp_valid_reg <= (state_reg == ST_SCAN);
            if (req_accept) begin
                found_reg <= 1'b0;
            end else if (candidate && (!found_reg || (cand_left >= best_left_reg))) begin
                found_reg <= 1'b1;
            end
            if (finish_fire) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Scan and result payload, no reset needed.
    always_ff @(posedge aclk) begin
        if (req_accept) begin
            req_reg      <= in_size;
            limit_reg    <= cfg_limit;
            scan_idx_reg <= '0;
        end else if (state_reg == ST_SCAN) begin
            scan_idx_reg <= scan_idx_reg + IDX_W'(1);
        end
        cmp_idx_reg <= scan_idx_reg;
        if (candidate && (!found_reg || (cand_left >= best_left_reg))) begin
            best_idx_reg  <= cmp_idx_reg;
            best_left_reg <= cand_left;
        end
        if (finish_fire) begin
            granted_reg  <= found_reg;
            chosen_reg   <= found_reg ? best_idx_reg : '0;
            leftover_reg <= found_reg ? best_left_reg : '0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = granted_reg;
    assign m_tdata  = {{(M_TDATA_W - IDX_W - SIZE_WIDTH){1'b0}}, leftover_reg, chosen_reg};

    `WFPA_ASSERT_SAME(a_refused_is_zero, m_tvalid_reg && !granted_reg,
        (chosen_reg == '0) && (leftover_reg == '0), "refused result carries nonzero fields")
    `WFPA_ASSERT_NEXT(a_grant_marks_taken, finish_fire && found_reg,
        taken_reg[$past(best_idx_reg)], "granted block not marked taken")
    `WFPA_ASSERT_SAME(a_scan_in_range, state_reg == ST_SCAN,
        {1'b0, scan_idx_reg} < limit_reg, "scan index beyond the in-use count")
    `WFPA_ASSERT_SAME(a_no_compare_idle, state_reg == ST_IDLE || state_reg == ST_FINISH,
        !cmp_valid_reg, "compare stage active outside a scan")

endmodule
